[hdl/bdtw_pkg.sv]
// Package for the banded DTW sequence score core.
// Holds shared constants, codes, the job and status structs and the FSM state type.
package bdtw_pkg;

    localparam int MAX_FRAMES = 64;

    localparam int DIST_W  = 23;
    localparam int SIM_W   = 16;
    localparam int BAND_W  = 8;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 2;
    localparam int FRAME_CFG_W = 7;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [SIM_W-1:0]  ONE_Q15  = 16'h8000;

    localparam logic [IDX_W-1:0] REG_REAL_FRAMES     = 2'd0;
    localparam logic [IDX_W-1:0] REG_TEMPLATE_FRAMES = 2'd1;
    localparam logic [IDX_W-1:0] REG_BAND_WIDTH      = 2'd2;

    localparam logic [1:0] STATUS_EXACT = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    localparam logic [BAND_W-1:0] BAND_MIN_DEFAULT = 8'd10;
    localparam int FIFTH_MUL   = 205;
    localparam int FIFTH_SHIFT = 10;

    localparam int DIV_NW = 40;
    localparam int DIV_DW = 26;
    localparam int DIV_QW = 16;

    typedef struct packed {
        logic empty;
    } t_job;

    typedef struct packed {
        logic pass_done;
    } t_back_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DIVN,
        S_ROW,
        S_DIAG,
        S_RD,
        S_CELL,
        S_NEXT,
        S_SCORE,
        S_SCOREW,
        S_EMIT
    } t_state;

endpackage

[hdl/banded_dtw_sequence_score_core.sv]
// Banded DTW sequence score core: loads an M x N similarity matrix, one cell per
// transaction, then runs one banded DTW pass and emits distance, score and status.
// Loading is stalled while a pass is running or the queue is full; the back part then pops
// the job, divides N by M, walks the band cells of each row, divides for the score and emits.
// Empty configs skip the pass and go straight to the result; the next matrix loads once
// the pass ends. Synchronous active-low reset clears the counters, config, queue and FSM.
module banded_dtw_sequence_score_core #(
    parameter int P_MAX_FRAMES = bdtw_pkg::MAX_FRAMES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bdtw_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [bdtw_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bdtw_pkg::SIM_W-1:0]   i_similarity,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bdtw_pkg::DIST_W-1:0]  o_distance,
    output logic [bdtw_pkg::SIM_W-1:0]   o_score,
    output logic [1:0]                   o_status,
    output logic [bdtw_pkg::BAND_W-1:0]  o_final_band
);

    localparam int FW  = $clog2(P_MAX_FRAMES + 1);
    localparam int CAW = $clog2(P_MAX_FRAMES * P_MAX_FRAMES);

    logic [FW-1:0]                  m;
    logic [FW-1:0]                  n;
    logic [bdtw_pkg::BAND_W-1:0]    bw;
    logic                           store_we;
    logic [CAW-1:0]                 store_waddr;
    logic [bdtw_pkg::SIM_W-1:0]     store_wdata;
    logic [CAW-1:0]                 store_raddr;
    logic [bdtw_pkg::SIM_W-1:0]     store_rdata;
    logic                           job_push;
    bdtw_pkg::t_job                 job_in;
    bdtw_pkg::t_job                 job_out;
    logic                           job_valid;
    logic                           job_pop;
    logic                           queue_full;
    bdtw_pkg::t_back_stat           back_stat;

    bdtw_front #(
        .P_MAX_FRAMES (P_MAX_FRAMES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_similarity  (i_similarity),
        .o_m           (m),
        .o_n           (n),
        .o_bw          (bw),
        .o_store_we    (store_we),
        .o_store_waddr (store_waddr),
        .o_store_wdata (store_wdata),
        .o_job_push    (job_push),
        .o_job         (job_in),
        .i_queue_full  (queue_full),
        .i_back_stat   (back_stat)
    );

    bdtw_ram #(
        .WIDTH (bdtw_pkg::SIM_W),
        .DEPTH (P_MAX_FRAMES * P_MAX_FRAMES)
    ) u_cell_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    bdtw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_full  (queue_full),
        .o_job   (job_out)
    );

    bdtw_back #(
        .P_MAX_FRAMES (P_MAX_FRAMES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (job_out),
        .o_job_pop     (job_pop),
        .i_m           (m),
        .i_n           (n),
        .i_bw_cfg      (bw),
        .o_store_raddr (store_raddr),
        .i_store_rdata (store_rdata),
        .o_back_stat   (back_stat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_distance    (o_distance),
        .o_score       (o_score),
        .o_status      (o_status),
        .o_final_band  (o_final_band)
    );

endmodule

[hdl/bdtw_ram.sv]
// Generic simple dual-port RAM with registered read.
// One write port, one read port; no dependencies.
module bdtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bdtw_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on bdtw_pkg for operand widths.
module bdtw_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bdtw_pkg::DIV_NW-1:0]  i_dividend,
    input  logic [bdtw_pkg::DIV_DW-1:0]  i_divisor,
    output logic                         o_done,
    output logic [bdtw_pkg::DIV_QW-1:0]  o_quotient,
    output logic [bdtw_pkg::DIV_DW-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(bdtw_pkg::DIV_QW);

    logic [bdtw_pkg::DIV_DW-1:0] r_rem;
    logic [bdtw_pkg::DIV_DW-1:0] r_div;
    logic [bdtw_pkg::DIV_QW-1:0] r_num;
    logic [bdtw_pkg::DIV_QW-1:0] r_quo;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [bdtw_pkg::DIV_DW:0]   trial;
    logic                        fits;

    always_comb begin
        trial = {r_rem, r_num[r_cnt]};
        fits  = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= bdtw_pkg::DIV_DW'(i_dividend >> bdtw_pkg::DIV_QW);
            r_num <= i_dividend[bdtw_pkg::DIV_QW-1:0];
            r_div <= i_divisor;
            r_quo <= '0;
            r_cnt <= CNT_W'(bdtw_pkg::DIV_QW - 1);
        end else if (r_busy) begin
            r_rem <= fits ? bdtw_pkg::DIV_DW'(trial - {1'b0, r_div})
                          : bdtw_pkg::DIV_DW'(trial);
            r_quo <= {r_quo[bdtw_pkg::DIV_QW-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[hdl/bdtw_queue.sv]
// Two-entry job queue between the front and back parts.
// Depends on bdtw_pkg for the job type.
module bdtw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bdtw_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output bdtw_pkg::t_job o_job
);

    bdtw_pkg::t_job r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic           do_push;
    logic           do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_job   = r_mem[r_rd];

endmodule

[hdl/bdtw_front.sv]
// Front part: configuration registers, cell loading and job classification.
// Depends on bdtw_pkg.
module bdtw_front #(
    parameter int P_MAX_FRAMES = bdtw_pkg::MAX_FRAMES,
    localparam int FW  = $clog2(P_MAX_FRAMES + 1),
    localparam int CAW = $clog2(P_MAX_FRAMES * P_MAX_FRAMES),
    localparam int CW  = $clog2(P_MAX_FRAMES * P_MAX_FRAMES + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bdtw_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [bdtw_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bdtw_pkg::SIM_W-1:0]     i_similarity,
    output logic [FW-1:0]                  o_m,
    output logic [FW-1:0]                  o_n,
    output logic [bdtw_pkg::BAND_W-1:0]    o_bw,
    output logic                           o_store_we,
    output logic [CAW-1:0]                 o_store_waddr,
    output logic [bdtw_pkg::SIM_W-1:0]     o_store_wdata,
    output logic                           o_job_push,
    output bdtw_pkg::t_job                 o_job,
    input  logic                           i_queue_full,
    input  bdtw_pkg::t_back_stat           i_back_stat
);

    logic [bdtw_pkg::FRAME_CFG_W-1:0] r_m_cfg;
    logic [bdtw_pkg::FRAME_CFG_W-1:0] r_n_cfg;
    logic [bdtw_pkg::BAND_W-1:0]      r_bw;
    logic [CW-1:0]                    r_count;
    logic                             r_busy;
    logic [FW-1:0]                    m_clamped;
    logic [FW-1:0]                    n_clamped;
    logic [CW-1:0]                    cells;
    logic                             cfg_we;
    logic                             accept;
    logic                             is_empty;
    logic                             is_last;

    always_comb begin
        m_clamped = (32'(r_m_cfg) > P_MAX_FRAMES) ? FW'(P_MAX_FRAMES) : FW'(r_m_cfg);
        n_clamped = (32'(r_n_cfg) > P_MAX_FRAMES) ? FW'(P_MAX_FRAMES) : FW'(r_n_cfg);
        cells     = CW'(32'(m_clamped) * 32'(n_clamped));
        cfg_we    = i_cfg_valid;
        accept    = i_in_valid && !o_in_stall;
        is_empty  = cells == '0;
        is_last   = (r_count + 1'b1) == cells;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_cfg <= '0;
            r_n_cfg <= '0;
            r_bw    <= '0;
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (i_cfg_index)
                    bdtw_pkg::REG_REAL_FRAMES: begin
                        r_m_cfg <= i_cfg_data[bdtw_pkg::FRAME_CFG_W-1:0];
                        r_count <= '0;
                    end
                    bdtw_pkg::REG_TEMPLATE_FRAMES: begin
                        r_n_cfg <= i_cfg_data[bdtw_pkg::FRAME_CFG_W-1:0];
                        r_count <= '0;
                    end
                    bdtw_pkg::REG_BAND_WIDTH: begin
                        r_bw    <= i_cfg_data;
                        r_count <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (accept && !is_empty) begin
                r_count <= is_last ? '0 : r_count + 1'b1;
            end
            if (accept && !is_empty && is_last) begin
                r_busy <= 1'b1;
            end else if (i_back_stat.pass_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_stall    = r_busy || i_queue_full;
    assign o_m           = m_clamped;
    assign o_n           = n_clamped;
    assign o_bw          = r_bw;
    assign o_store_we    = accept && !is_empty;
    assign o_store_waddr = r_count[CAW-1:0];
    assign o_store_wdata = i_similarity;
    assign o_job_push    = accept && (is_empty || is_last);
    assign o_job.empty   = is_empty;

endmodule

[hdl/bdtw_back.sv]
// Back part: banded DTW pass over the stored matrix, score division, result register.
// Depends on bdtw_pkg, bdtw_ram and bdtw_div.
module bdtw_back #(
    parameter int P_MAX_FRAMES = bdtw_pkg::MAX_FRAMES,
    localparam int FW  = $clog2(P_MAX_FRAMES + 1),
    localparam int CAW = $clog2(P_MAX_FRAMES * P_MAX_FRAMES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  bdtw_pkg::t_job                i_job,
    output logic                          o_job_pop,
    input  logic [FW-1:0]                 i_m,
    input  logic [FW-1:0]                 i_n,
    input  logic [bdtw_pkg::BAND_W-1:0]   i_bw_cfg,
    output logic [CAW-1:0]                o_store_raddr,
    input  logic [bdtw_pkg::SIM_W-1:0]    i_store_rdata,
    output bdtw_pkg::t_back_stat          o_back_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bdtw_pkg::DIST_W-1:0]   o_distance,
    output logic [bdtw_pkg::SIM_W-1:0]    o_score,
    output logic [1:0]                    o_status,
    output logic [bdtw_pkg::BAND_W-1:0]   o_final_band
);

    localparam int DW = bdtw_pkg::DIST_W;
    localparam int BW = bdtw_pkg::BAND_W;
    localparam int SW = 11;

    bdtw_pkg::t_state r_state;
    bdtw_pkg::t_state n_state;

    logic [FW-1:0]   r_i, r_j, r_js, r_je, r_jsp, r_jep;
    logic [FW-1:0]   r_q, r_r, r_qn, r_rn;
    logic [CAW-1:0]  r_base;
    logic [BW-1:0]   r_bw;
    logic [DW-1:0]   r_left, r_diag, r_dist;
    logic            r_first;
    logic [bdtw_pkg::SIM_W-1:0] r_score;
    logic [1:0]      r_status;
    logic [BW-1:0]   r_band;
    logic            r_out_valid;
    logic [DW-1:0]   r_out_dist;
    logic [bdtw_pkg::SIM_W-1:0] r_out_score;
    logic [1:0]      r_out_status;
    logic [BW-1:0]   r_out_band;

    logic            job_pop;
    logic            div_start;
    logic            div_done;
    logic [bdtw_pkg::DIV_QW-1:0] div_quo;
    logic [bdtw_pkg::DIV_DW-1:0] div_rem;
    logic [bdtw_pkg::DIV_NW-1:0] div_num;
    logic [bdtw_pkg::DIV_DW-1:0] div_den;
    logic [bdtw_pkg::DIV_NW-1:0] den_full;

    logic [FW-1:0]   row_raddr;
    logic [DW-1:0]   row_rdata;
    logic            row_we;
    logic [DW-1:0]   cell_val;

    logic [FW-1:0]   mn;
    logic [19:0]     fifth_prod;
    logic [BW-1:0]   fifth;
    logic [BW-1:0]   bw_init;
    logic signed [SW-1:0] t_lo;
    logic [SW-1:0]   t_hi;
    logic [FW-1:0]   js_c, je_c;
    logic [FW:0]     r_sum;
    logic [FW-1:0]   q_next, r_next;

    logic [bdtw_pkg::SIM_W-1:0] cost;
    logic            up_ok, left_ok, diag_ok, any_ok;
    logic [DW-1:0]   diag_val, best;
    logic [DW:0]     add_sum;
    logic [bdtw_pkg::SIM_W+FW-1:0] prod;
    logic            take_out;

    bdtw_ram #(
        .WIDTH (DW),
        .DEPTH (P_MAX_FRAMES + 1)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_j),
        .i_wdata (cell_val),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    bdtw_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_num),
        .i_divisor   (div_den),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        mn         = (i_m < i_n) ? i_m : i_n;
        fifth_prod = 20'(mn) * 20'(bdtw_pkg::FIFTH_MUL);
        fifth      = BW'(fifth_prod >> bdtw_pkg::FIFTH_SHIFT);
        if (i_bw_cfg != '0) begin
            bw_init = i_bw_cfg;
        end else begin
            bw_init = (fifth > bdtw_pkg::BAND_MIN_DEFAULT) ? fifth
                                                           : bdtw_pkg::BAND_MIN_DEFAULT;
        end

        den_full = (bdtw_pkg::DIV_NW'(i_m > i_n ? i_m : i_n) << 15)
                 + bdtw_pkg::DIV_NW'(r_dist);
        if (r_state == bdtw_pkg::S_SETUP) begin
            div_num = bdtw_pkg::DIV_NW'(i_n);
            div_den = bdtw_pkg::DIV_DW'(i_m);
        end else begin
            div_num = (bdtw_pkg::DIV_NW'(i_m > i_n ? i_m : i_n) << 31) + den_full;
            div_den = bdtw_pkg::DIV_DW'(den_full << 1);
        end

        t_lo = $signed(SW'(r_q)) + $signed(SW'(r_r != '0)) - $signed(SW'(r_bw));
        t_hi = SW'(r_q) + SW'(r_bw);
        if (SW'(r_bw) < SW'(i_n)) begin
            if (t_lo <= 0) begin
                js_c = FW'(1);
            end else if (t_lo > $signed(SW'(i_n))) begin
                js_c = i_n;
            end else begin
                js_c = FW'(t_lo);
            end
            je_c = (t_hi > SW'(i_n)) ? i_n : FW'(t_hi);
        end else begin
            js_c = FW'(1);
            je_c = i_n;
        end

        r_sum = {1'b0, r_r} + {1'b0, r_rn};
        if (r_sum >= {1'b0, i_m}) begin
            r_next = FW'(r_sum - {1'b0, i_m});
            q_next = r_q + r_qn + 1'b1;
        end else begin
            r_next = FW'(r_sum);
            q_next = r_q + r_qn;
        end

        cost = (i_store_rdata >= bdtw_pkg::ONE_Q15) ? '0
                                                    : bdtw_pkg::ONE_Q15 - i_store_rdata;
        if (r_i == FW'(1)) begin
            up_ok    = 1'b0;
            diag_ok  = r_j == FW'(1);
            diag_val = '0;
        end else begin
            up_ok    = (r_j >= r_jsp) && (r_j <= r_jep);
            diag_ok  = ((r_j - 1'b1) >= r_jsp) && ((r_j - 1'b1) <= r_jep);
            diag_val = r_diag;
        end
        left_ok = r_j > r_js;
        any_ok  = up_ok || left_ok || diag_ok;
        best    = bdtw_pkg::DIST_MAX;
        if (up_ok && row_rdata < best) begin
            best = row_rdata;
        end
        if (left_ok && r_left < best) begin
            best = r_left;
        end
        if (diag_ok && diag_val < best) begin
            best = diag_val;
        end
        add_sum = {1'b0, best} + (DW + 1)'(cost);
        prod    = (bdtw_pkg::SIM_W + FW)'(cost) * (bdtw_pkg::SIM_W + FW)'(r_i);
        if (any_ok) begin
            cell_val = (add_sum > (DW + 1)'(bdtw_pkg::DIST_MAX)) ? bdtw_pkg::DIST_MAX
                                                                 : add_sum[DW-1:0];
        end else begin
            cell_val = ((bdtw_pkg::SIM_W + FW)'(bdtw_pkg::DIST_MAX) < prod)
                     ? bdtw_pkg::DIST_MAX : DW'(prod);
        end
    end

    assign take_out = r_out_valid && !i_out_stall;

    always_comb begin
        n_state     = r_state;
        job_pop     = 1'b0;
        div_start   = 1'b0;
        row_we      = 1'b0;
        row_raddr   = r_j;
        o_back_stat = '0;
        unique case (r_state)
            bdtw_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    job_pop = 1'b1;
                    n_state = i_job.empty ? bdtw_pkg::S_EMIT : bdtw_pkg::S_SETUP;
                end
            end
            bdtw_pkg::S_SETUP: begin
                div_start = 1'b1;
                n_state   = bdtw_pkg::S_DIVN;
            end
            bdtw_pkg::S_DIVN: begin
                if (div_done) begin
                    n_state = bdtw_pkg::S_ROW;
                end
            end
            bdtw_pkg::S_ROW: begin
                n_state = bdtw_pkg::S_DIAG;
            end
            bdtw_pkg::S_DIAG: begin
                row_raddr = r_js - 1'b1;
                n_state   = bdtw_pkg::S_RD;
            end
            bdtw_pkg::S_RD: begin
                n_state = bdtw_pkg::S_CELL;
            end
            bdtw_pkg::S_CELL: begin
                row_we = 1'b1;
                if (r_j == r_je) begin
                    if (r_i == i_m) begin
                        o_back_stat.pass_done = 1'b1;
                        n_state = bdtw_pkg::S_SCORE;
                    end else begin
                        n_state = bdtw_pkg::S_NEXT;
                    end
                end else begin
                    n_state = bdtw_pkg::S_RD;
                end
            end
            bdtw_pkg::S_NEXT: begin
                n_state = bdtw_pkg::S_ROW;
            end
            bdtw_pkg::S_SCORE: begin
                div_start = 1'b1;
                n_state   = bdtw_pkg::S_SCOREW;
            end
            bdtw_pkg::S_SCOREW: begin
                if (div_done) begin
                    n_state = bdtw_pkg::S_EMIT;
                end
            end
            bdtw_pkg::S_EMIT: begin
                if (!r_out_valid || take_out) begin
                    n_state = bdtw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bdtw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdtw_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bdtw_pkg::S_EMIT && (!r_out_valid || take_out)) begin
                r_out_valid <= 1'b1;
            end else if (take_out) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bdtw_pkg::S_IDLE: begin
                r_dist   <= '0;
                r_score  <= '0;
                r_status <= bdtw_pkg::STATUS_EMPTY;
                r_band   <= '0;
            end
            bdtw_pkg::S_SETUP: begin
                r_bw <= bw_init;
            end
            bdtw_pkg::S_DIVN: begin
                r_qn   <= FW'(div_quo);
                r_rn   <= FW'(div_rem);
                r_q    <= FW'(div_quo);
                r_r    <= FW'(div_rem);
                r_i    <= FW'(1);
                r_base <= '0;
            end
            bdtw_pkg::S_ROW: begin
                r_js    <= js_c;
                r_je    <= je_c;
                r_j     <= js_c;
                r_first <= 1'b1;
            end
            bdtw_pkg::S_DIAG: begin
            end
            bdtw_pkg::S_RD: begin
                if (r_first) begin
                    r_diag  <= row_rdata;
                    r_first <= 1'b0;
                end
            end
            bdtw_pkg::S_CELL: begin
                r_left <= cell_val;
                r_diag <= row_rdata;
                r_dist <= cell_val;
                if (r_j != r_je) begin
                    r_j <= r_j + 1'b1;
                end
            end
            bdtw_pkg::S_NEXT: begin
                r_i    <= r_i + 1'b1;
                r_q    <= q_next;
                r_r    <= r_next;
                r_base <= r_base + CAW'(i_n);
                r_jsp  <= r_js;
                r_jep  <= r_je;
            end
            bdtw_pkg::S_SCORE: begin
            end
            bdtw_pkg::S_SCOREW: begin
                r_score  <= div_quo;
                r_status <= bdtw_pkg::STATUS_EXACT;
                r_band   <= r_bw;
            end
            bdtw_pkg::S_EMIT: begin
                if (!r_out_valid || take_out) begin
                    r_out_dist   <= r_dist;
                    r_out_score  <= r_score;
                    r_out_status <= r_status;
                    r_out_band   <= r_band;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_store_raddr = r_base + CAW'(r_j - 1'b1);
    assign o_job_pop     = job_pop;
    assign o_out_valid   = r_out_valid;
    assign o_distance    = r_out_dist;
    assign o_score       = r_out_score;
    assign o_status      = r_out_status;
    assign o_final_band  = r_out_band;

endmodule

[hdl/bdtw_checker.sv]
// Port-level checker for the banded DTW sequence score core, bound to the top level.
// Depends on bdtw_pkg.
module bdtw_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [bdtw_pkg::DIST_W-1:0]  o_distance,
    input logic [bdtw_pkg::SIM_W-1:0]   o_score,
    input logic [1:0]                   o_status,
    input logic [bdtw_pkg::BAND_W-1:0]  o_final_band
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_distance)
            && $stable(o_score) && $stable(o_status) && $stable(o_final_band))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == bdtw_pkg::STATUS_EXACT
            || o_status == bdtw_pkg::STATUS_EMPTY))
        else $error("unexpected status");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == bdtw_pkg::STATUS_EMPTY |->
            o_distance == '0 && o_score == '0 && o_final_band == '0)
        else $error("empty result not zero");

    a_zero_dist_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == bdtw_pkg::STATUS_EXACT && o_distance == '0 |->
            o_score == bdtw_pkg::ONE_Q15)
        else $error("zero distance must score one");

    a_exact_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == bdtw_pkg::STATUS_EXACT |-> o_final_band != '0)
        else $error("exact result without band");

endmodule

bind banded_dtw_sequence_score_core bdtw_checker u_bdtw_checker (.*);
